// ===== hw/rtl/xmltok_pkg.sv =====
// ----------------------------------------------------------------------------
// xmltok_pkg: shared types and constants of the XML markup tokenizer
// Character codes, scanner modes and the codes of the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xmltok_pkg;

	localparam int unsigned SYM_W = 21;

	// markup characters
	localparam logic [SYM_W-1:0] CH_LT = 21'h00003C;
	localparam logic [SYM_W-1:0] CH_GT = 21'h00003E;
	localparam logic [SYM_W-1:0] CH_QM = 21'h00003F;
	localparam logic [SYM_W-1:0] CH_SL = 21'h00002F;

	// scanner position between and inside tokens
	typedef enum logic [3:0] {
		MODE_IDLE     = 4'd0,
		MODE_TEXT     = 4'd1,
		MODE_LT       = 4'd2,
		MODE_DECL     = 4'd3,
		MODE_OT_NAME  = 4'd4,
		MODE_CT_FIRST = 4'd5,
		MODE_CT_NAME  = 4'd6,
		MODE_HALT     = 4'd7
	} mode_t;

	typedef enum logic [1:0] {
		CK_MARKUP = 2'd0,
		CK_TEXT   = 2'd1,
		CK_OPEN   = 2'd2,
		CK_CLOSE  = 2'd3
	} content_t;

	typedef enum logic [2:0] {
		END_NONE  = 3'd0,
		END_TEXT  = 3'd1,
		END_OPEN  = 3'd2,
		END_CLOSE = 3'd3,
		END_DECL  = 3'd4
	} endk_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EMPTY_NAME = 3'd1,
		ST_OPEN_TAG   = 3'd2,
		ST_OPEN_TEXT  = 3'd3,
		ST_HALTED     = 3'd4
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xml_markup_tokenizer.sv =====
// ----------------------------------------------------------------------------
// xml_markup_tokenizer: streaming splitter of a document into markup tokens
// Labels each character as markup, text, open-tag name or close-tag name content.
// ----------------------------------------------------------------------------
// One character per beat enters, one labelled beat leaves per character. The
// block sustains one character per clock cycle while out_stall is low; each
// character passes the input register, then the result register. The only
// feedback path is the scanner mode register, updated in the cycle the
// character moves into the result register from a handful of 21-bit compares.
// Declarations '<?...>' come out as markup. After an error every beat reports
// halted until the beat flagged last, which returns the scanner to idle.
`timescale 1ns / 1ps
`default_nettype none

module xml_markup_tokenizer
	import xmltok_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// character input
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [SYM_W-1:0] symbol,
	input  wire logic             last,
	// labelled output
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            content_kind,
	output logic [SYM_W-1:0]      symbol_out,
	output logic [2:0]            end_kind,
	output logic [2:0]            status
);

	logic             valid_s1;
	logic [SYM_W-1:0] symbol_s1;
	logic             last_s1;

	mode_t            mode_q;
	mode_t            base_next;
	mode_t            mode_next;
	content_t         base_content;
	endk_t            base_end;
	status_t          base_status;
	content_t         res_content;
	endk_t            res_end;
	status_t          res_status;

	logic             out_valid_q;
	logic [1:0]       content_q;
	logic [SYM_W-1:0] symbol_q;
	logic [2:0]       end_q;
	logic [2:0]       status_q;

	logic             adv_out;
	logic             adv_in;

	// flow control: result register frees up, input register follows
	assign adv_out  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_out;
	assign adv_in   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_out || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_in) begin
			symbol_s1 <= symbol;
			last_s1   <= last;
		end
	end

	// next mode before error handling
	always_comb begin
		base_next = mode_q;
		case (mode_q)
			MODE_IDLE:     base_next = (symbol_s1 == CH_LT) ? MODE_LT : MODE_TEXT;
			MODE_TEXT:     if (symbol_s1 == CH_LT) base_next = MODE_LT;
			MODE_LT: begin
				if (symbol_s1 == CH_QM)      base_next = MODE_DECL;
				else if (symbol_s1 == CH_SL) base_next = MODE_CT_FIRST;
				else if (symbol_s1 != CH_GT) base_next = MODE_OT_NAME;
			end
			MODE_DECL:     if (symbol_s1 == CH_GT) base_next = MODE_IDLE;
			MODE_OT_NAME:  if (symbol_s1 == CH_GT) base_next = MODE_IDLE;
			MODE_CT_FIRST: if (symbol_s1 != CH_GT) base_next = MODE_CT_NAME;
			MODE_CT_NAME:  if (symbol_s1 == CH_GT) base_next = MODE_IDLE;
			default:       base_next = mode_q;
		endcase
	end

	// labels before error handling
	always_comb begin
		base_content = CK_MARKUP;
		base_end     = END_NONE;
		base_status  = ST_OK;
		case (mode_q)
			MODE_IDLE: begin
				if (symbol_s1 != CH_LT) base_content = CK_TEXT;
			end
			MODE_TEXT: begin
				if (symbol_s1 == CH_LT) base_end = END_TEXT;
				else                    base_content = CK_TEXT;
			end
			MODE_LT: begin
				if (symbol_s1 == CH_GT) base_status = ST_EMPTY_NAME;
				else if (symbol_s1 != CH_QM && symbol_s1 != CH_SL) base_content = CK_OPEN;
			end
			MODE_DECL: begin
				if (symbol_s1 == CH_GT) base_end = END_DECL;
			end
			MODE_OT_NAME: begin
				if (symbol_s1 == CH_GT) base_end = END_OPEN;
				else                    base_content = CK_OPEN;
			end
			MODE_CT_FIRST: begin
				if (symbol_s1 == CH_GT) base_status = ST_EMPTY_NAME;
				else                    base_content = CK_CLOSE;
			end
			MODE_CT_NAME: begin
				if (symbol_s1 == CH_GT) base_end = END_CLOSE;
				else                    base_content = CK_CLOSE;
			end
			default: base_status = ST_HALTED;
		endcase
	end

	// end of document inside a token, then error override
	always_comb begin
		res_status = base_status;
		if (base_status == ST_OK && last_s1 && base_next != MODE_IDLE) begin
			res_status = (base_next == MODE_TEXT) ? ST_OPEN_TEXT : ST_OPEN_TAG;
		end
		res_content = base_content;
		res_end     = base_end;
		mode_next   = base_next;
		if (res_status != ST_OK) begin
			res_content = CK_MARKUP;
			res_end     = END_NONE;
			mode_next   = last_s1 ? MODE_IDLE : MODE_HALT;
		end
	end

	// scanner mode advances as the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
			if (valid_s1) mode_q <= mode_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			content_q <= res_content;
			symbol_q  <= symbol_s1;
			end_q     <= res_end;
			status_q  <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign content_kind = content_q;
	assign symbol_out   = symbol_q;
	assign end_kind     = end_q;
	assign status       = status_q;

	// an error beat carries no content and no end mark
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |->
		(content_q == CK_MARKUP && end_q == END_NONE))
		else $error("error beat carries content or end mark");

	// a beat flagged last always leaves the scanner idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_out && valid_s1 && last_s1) |=> (mode_q == MODE_IDLE))
		else $error("scanner not idle after last beat");

	// a beat processed while halted reports halted
	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_out && valid_s1 && mode_q == MODE_HALT) |=> (status_q == ST_HALTED))
		else $error("halted scanner gave a non-halted status");

	// a text run only ends on '<'
	a_text_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_q == END_TEXT) |-> (symbol_q == CH_LT))
		else $error("text end mark on a character other than '<'");

endmodule

`default_nettype wire
